[src/alph_pkg.sv]
// Package for the audio level peak-hold meter: field widths, configuration
// register indexes, micro-op encodings and the control program ROM.
// No dependencies.
`default_nettype none

package alph_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int BL_W       = 10;
    localparam int DF_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int PC_W       = 4;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic {
        CFG_BLOCK_LENGTH = 1'b0,
        CFG_DECAY_FACTOR = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SQUARE,
        OP_ACCUM,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_DECAY,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        CND_NEXT,
        CND_JUMP,
        CND_TICK,
        CND_LOOP,
        CND_OPEN
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    localparam t_pc PC_ACCEPT    = 4'd0;
    localparam t_pc PC_SQUARE    = 4'd1;
    localparam t_pc PC_ACCUM     = 4'd2;
    localparam t_pc PC_SQRT_LOAD = 4'd3;
    localparam t_pc PC_SQRT_STEP = 4'd4;
    localparam t_pc PC_DIV_LOAD  = 4'd5;
    localparam t_pc PC_DIV_STEP  = 4'd6;
    localparam t_pc PC_UPDATE    = 4'd7;
    localparam t_pc PC_DECAY     = 4'd8;
    localparam t_pc PC_EMIT      = 4'd9;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_ACCEPT:    w = '{OP_ACCEPT,    CND_TICK, PC_DECAY};
            PC_SQUARE:    w = '{OP_SQUARE,    CND_NEXT, PC_ACCUM};
            PC_ACCUM:     w = '{OP_ACCUM,     CND_OPEN, PC_EMIT};
            PC_SQRT_LOAD: w = '{OP_SQRT_LOAD, CND_NEXT, PC_SQRT_STEP};
            PC_SQRT_STEP: w = '{OP_SQRT_STEP, CND_LOOP, PC_SQRT_STEP};
            PC_DIV_LOAD:  w = '{OP_DIV_LOAD,  CND_NEXT, PC_DIV_STEP};
            PC_DIV_STEP:  w = '{OP_DIV_STEP,  CND_LOOP, PC_DIV_STEP};
            PC_UPDATE:    w = '{OP_UPDATE,    CND_JUMP, PC_EMIT};
            PC_DECAY:     w = '{OP_DECAY,     CND_NEXT, PC_EMIT};
            PC_EMIT:      w = '{OP_EMIT,      CND_JUMP, PC_ACCEPT};
            default:      w = '{OP_NOP,       CND_JUMP, PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[src/audio_level_peak_hold_core.sv]
// Peak-hold audio level meter with decay, run by a microcoded sequencer.
// Depends on alph_pkg (widths, micro-op codes, control ROM).
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   input    | i_in_valid / o_in_ready    | i_cmd, i_sample
//   output   | o_out_valid / i_out_ready  | o_held_level_out, o_block_done
//   config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A tick runs accept, decay and emit; a sample that does not close a block runs
// accept, square, accumulate and emit. A sample that closes a block also runs the
// bit-per-cycle square root and restoring divide loops and the update step.
// The output register lets the next word be accepted while a result waits;
// the emit step holds only if the previous result has not been taken.
// Reset is synchronous, active low, and clears sum, count and held level.
`default_nettype none

module audio_level_peak_hold_core #(
    parameter int MAX_BLOCK = 512
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_cmd,
    input  wire logic signed [alph_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [alph_pkg::LEVEL_W-1:0]            o_held_level_out,
    output logic                                    o_block_done,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_index,
    input  wire logic [alph_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import alph_pkg::*;

    localparam int NMAX   = (MAX_BLOCK < 1023) ? MAX_BLOCK : 1023;
    localparam int SUM_W  = 31 + $clog2(NMAX);
    localparam int RAD_W  = SUM_W + 2 + (SUM_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int IT_W   = $clog2(ROOT_W + 1);

    t_pc                  r_pc, n_pc;
    t_uword               uw;
    logic [BL_W-1:0]      r_bl;
    logic [DF_W-1:0]      r_df;
    logic [SUM_W-1:0]     r_sum;
    logic [BL_W-1:0]      r_count;
    logic [LEVEL_W-1:0]   r_held;
    logic [SAMPLE_W-1:0]  r_mag;
    logic [31:0]          r_prod;
    logic [RAD_W-1:0]     r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [ROOT_W-1:0]    r_quo;
    logic [BL_W:0]        r_drem;
    logic [IT_W-1:0]      r_iter;
    logic                 r_done;
    logic                 r_out_valid;
    logic [LEVEL_W-1:0]   r_out_held;
    logic                 r_out_done;

    logic                 in_fire;
    logic                 advance;
    logic                 take;
    logic [BL_W-1:0]      n_eff;
    logic [BL_W-1:0]      count_inc;
    logic                 closing;
    logic [SAMPLE_W-1:0]  mag_in;
    logic [15:0]          mul_a;
    logic [15:0]          mul_b;
    logic [31:0]          mul_p;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 sq_bit;
    logic [BL_W:0]        drem_sh;
    logic                 q_bit;
    logic [LEVEL_W-1:0]   level;

    assign uw          = ucode(r_pc);
    assign o_in_ready  = (uw.op == OP_ACCEPT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_held_level_out = r_out_held;
    assign o_block_done     = r_out_done;

    always_comb begin
        if (r_bl == '0) begin
            n_eff = BL_W'(1);
        end else if (int'(r_bl) > MAX_BLOCK) begin
            n_eff = BL_W'(MAX_BLOCK);
        end else begin
            n_eff = r_bl;
        end
    end

    assign count_inc = r_count + BL_W'(1);
    assign closing   = (count_inc >= n_eff);
    assign mag_in    = i_sample[SAMPLE_W-1] ? SAMPLE_W'(-i_sample) : SAMPLE_W'(i_sample);

    always_comb begin
        if (uw.op == OP_DECAY) begin
            mul_a = r_held;
            mul_b = r_df;
        end else begin
            mul_a = r_mag;
            mul_b = r_mag;
        end
    end
    assign mul_p = mul_a * mul_b;

    assign rem_sh  = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial   = {r_root, 2'b01};
    assign sq_bit  = (rem_sh >= trial);
    assign drem_sh = {r_drem[BL_W-1:0], r_quo[ROOT_W-1]};
    assign q_bit   = (drem_sh >= {1'b0, n_eff});
    assign level   = (|r_quo[ROOT_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : r_quo[LEVEL_W-1:0];

    always_comb begin
        advance = 1'b1;
        if (uw.op == OP_ACCEPT && !in_fire) begin
            advance = 1'b0;
        end else if (uw.op == OP_EMIT && r_out_valid && !i_out_ready) begin
            advance = 1'b0;
        end
        unique case (uw.cond)
            CND_NEXT: take = 1'b0;
            CND_JUMP: take = 1'b1;
            CND_TICK: take = (i_cmd == CMD_TICK);
            CND_LOOP: take = (r_iter != IT_W'(1));
            CND_OPEN: take = !closing;
            default:  take = 1'b0;
        endcase
        if (!advance) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_ACCEPT;
            r_bl        <= BL_W'(512);
            r_df        <= DF_W'(54613);
            r_sum       <= '0;
            r_count     <= '0;
            r_held      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_BLOCK_LENGTH: r_bl <= i_cfg_data[BL_W-1:0];
                    CFG_DECAY_FACTOR: r_df <= i_cfg_data[DF_W-1:0];
                    default:          r_bl <= r_bl;
                endcase
            end
            if (uw.op == OP_EMIT && advance) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (uw.op)
                OP_ACCEPT: begin
                    if (in_fire) begin
                        r_mag  <= mag_in;
                        r_done <= 1'b0;
                    end
                end
                OP_SQUARE: begin
                    r_prod <= mul_p;
                end
                OP_ACCUM: begin
                    r_sum   <= r_sum + SUM_W'(r_prod);
                    r_count <= count_inc;
                end
                OP_SQRT_LOAD: begin
                    r_rad  <= RAD_W'({r_sum, 2'b00});
                    r_rem  <= '0;
                    r_root <= '0;
                    r_iter <= IT_W'(ROOT_W);
                end
                OP_SQRT_STEP: begin
                    r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                    r_rem  <= sq_bit ? (rem_sh - trial) : rem_sh;
                    r_root <= {r_root[ROOT_W-2:0], sq_bit};
                    r_iter <= r_iter - IT_W'(1);
                end
                OP_DIV_LOAD: begin
                    r_quo  <= r_root;
                    r_drem <= '0;
                    r_iter <= IT_W'(ROOT_W);
                end
                OP_DIV_STEP: begin
                    r_drem <= q_bit ? (drem_sh - {1'b0, n_eff}) : drem_sh;
                    r_quo  <= {r_quo[ROOT_W-2:0], q_bit};
                    r_iter <= r_iter - IT_W'(1);
                end
                OP_UPDATE: begin
                    if (level > r_held) begin
                        r_held <= level;
                    end
                    r_sum   <= '0;
                    r_count <= '0;
                    r_done  <= 1'b1;
                end
                OP_DECAY: begin
                    r_held <= mul_p[31:16];
                end
                OP_EMIT: begin
                    if (advance) begin
                        r_out_held  <= r_held;
                        r_out_done  <= r_done;
                    end
                end
                default: begin
                    r_done <= r_done;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[dv/alph_level_checker.sv]
// Checker for the audio level peak-hold meter: watches the input, output and
// register ports, predicts every result word and compares it field by field.
// Depends on alph_pkg for widths, command codes and register indexes.
module alph_level_checker #(
    parameter int MAX_BLOCK = 512
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    input  wire logic                                  i_in_ready,
    input  wire logic                                  i_cmd,
    input  wire logic signed [alph_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                                  i_out_valid,
    input  wire logic                                  i_out_ready,
    input  wire logic [alph_pkg::LEVEL_W-1:0]          i_held_level_out,
    input  wire logic                                  i_block_done,
    input  wire logic                                  i_cfg_we,
    input  wire logic                                  i_cfg_index,
    input  wire logic [alph_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output int                                         o_errors,
    output int                                         o_words_in,
    output int                                         o_words_out
);
    timeunit 1ns;
    timeprecision 1ps;

    import alph_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               done;
    } t_meter_word;

    t_meter_word        level_q[$];
    logic [BL_W-1:0]    blk_len;
    logic [DF_W-1:0]    decay;
    logic [39:0]        energy;
    logic [BL_W-1:0]    fill;
    logic [LEVEL_W-1:0] peak;

    function automatic logic [31:0] root_of(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v) begin
                r = trial;
            end
        end
        return r;
    endfunction

    function automatic t_meter_word meter_step(input t_cmd c, input logic signed [15:0] s);
        t_meter_word w;
        logic [15:0] mag;
        logic [63:0] lvl;
        int unsigned n;
        w.done = 1'b0;
        if (c == CMD_TICK) begin
            peak = 16'((32'(peak) * 32'(decay)) >> 16);
        end else begin
            mag = s[15] ? 16'(~s + 16'd1) : 16'(s);
            energy = energy + 40'(mag) * 40'(mag);
            fill = fill + 1'b1;
            n = (blk_len == '0) ? 1 : ((blk_len > MAX_BLOCK) ? MAX_BLOCK : int'(blk_len));
            if (int'(fill) >= n) begin
                lvl = 64'(root_of(64'({energy, 2'b00}))) / n;
                if (lvl > 64'd65535) begin
                    lvl = 64'd65535;
                end
                if (lvl[15:0] > peak) begin
                    peak = lvl[15:0];
                end
                energy = '0;
                fill = '0;
                w.done = 1'b1;
            end
        end
        w.level = peak;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_meter_word want;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            blk_len = 10'd512;
            decay = 16'd54613;
            energy = '0;
            fill = '0;
            peak = '0;
            level_q.delete();
            o_errors <= 0;
            o_words_in <= 0;
            o_words_out <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BLOCK_LENGTH: blk_len = i_cfg_data[BL_W-1:0];
                    CFG_DECAY_FACTOR: decay = i_cfg_data[DF_W-1:0];
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_words_out <= o_words_out + 1;
                if (level_q.size() == 0) begin
                    $error("unexpected result word: held_level_out %0d block_done %0d",
                           i_held_level_out, i_block_done);
                    bad++;
                end else begin
                    want = level_q.pop_front();
                    if (want.level !== i_held_level_out) begin
                        $error("held_level_out: expected %0d, actual %0d",
                               want.level, i_held_level_out);
                        bad++;
                    end
                    if (want.done !== i_block_done) begin
                        $error("block_done: expected %0d, actual %0d",
                               want.done, i_block_done);
                        bad++;
                    end
                end
                o_errors <= o_errors + bad;
            end
            if (i_in_valid && i_in_ready) begin
                level_q.insert(level_q.size(), meter_step(t_cmd'(i_cmd), i_sample));
                o_words_in <= o_words_in + 1;
            end
        end
    end

endmodule

[dv/audio_level_peak_hold_core_test.sv]
// Testbench top for audio_level_peak_hold_core: clock, reset, register writes,
// directed and random sample/tick words, output back-pressure and the verdict.
// Depends on alph_pkg, the core and alph_level_checker.
module audio_level_peak_hold_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import alph_pkg::*;

    localparam int LONG_HOLD = 300;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          i_cmd = 1'b0;
    logic signed [SAMPLE_W-1:0]    i_sample = '0;
    logic                          i_out_ready = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    wire logic                     o_in_ready;
    wire logic                     o_out_valid;
    wire logic [LEVEL_W-1:0]       o_held_level_out;
    wire logic                     o_block_done;

    int meter_faults;
    int words_in;
    int words_out;
    int words_sent = 0;
    bit calm = 1'b0;
    bit long_hold_done = 1'b0;

    audio_level_peak_hold_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_held_level_out (o_held_level_out),
        .o_block_done     (o_block_done),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    alph_level_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_sample         (i_sample),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_held_level_out (o_held_level_out),
        .i_block_done     (o_block_done),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (meter_faults),
        .o_words_in       (words_in),
        .o_words_out      (words_out)
    );

    always #4ns i_clk = ~i_clk;

    initial begin
        #3ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && words_sent >= 200) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return 16'sd128 - 16'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic offer_word(input t_cmd c, input logic signed [15:0] s);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= c;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic settle();
        int spin;
        spin = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            spin++;
        end while (words_in != words_out && spin < 20000);
    endtask

    task automatic set_regs(input logic [BL_W-1:0] bl, input logic [DF_W-1:0] df);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_BLOCK_LENGTH;
        i_cfg_data <= {6'($urandom), bl};
        @(posedge i_clk);
        i_cfg_index <= CFG_DECAY_FACTOR;
        i_cfg_data <= df;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [BL_W-1:0] bl, input logic [DF_W-1:0] df,
                             input int count, input int tick_pct);
        settle();
        set_regs(bl, df);
        repeat (count) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                offer_word(CMD_TICK, 16'($urandom));
            end else begin
                offer_word(CMD_SAMPLE, pick_sample());
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, then full scale with a one-sample block
        offer_word(CMD_SAMPLE, 16'sh1234);
        offer_word(CMD_TICK, 16'sh0000);
        offer_word(CMD_SAMPLE, -16'sd7);
        settle();
        set_regs(10'd1, 16'hffff);
        offer_word(CMD_SAMPLE, 16'sh8000);
        offer_word(CMD_TICK, 16'shffff);
        offer_word(CMD_SAMPLE, 16'sh7fff);
        offer_word(CMD_SAMPLE, 16'sh0000);
        offer_word(CMD_SAMPLE, -16'sd1);
        offer_word(CMD_SAMPLE, 16'sd1);

        // zero block length acts as one, zero decay drops the hold
        settle();
        set_regs(10'd0, 16'h0000);
        offer_word(CMD_SAMPLE, 16'sh4000);
        offer_word(CMD_TICK, 16'sh5555);
        offer_word(CMD_SAMPLE, 16'sd1);

        // lower the block length mid-block
        settle();
        set_regs(10'd8, 16'h8000);
        offer_word(CMD_SAMPLE, 16'sh7fff);
        offer_word(CMD_SAMPLE, 16'sh8000);
        offer_word(CMD_SAMPLE, 16'sd1234);
        offer_word(CMD_SAMPLE, -16'sd1234);
        offer_word(CMD_SAMPLE, 16'sh0000);
        settle();
        set_regs(10'd3, 16'h8000);
        offer_word(CMD_SAMPLE, 16'sd100);
        offer_word(CMD_TICK, 16'sh0000);

        run_phase(10'd1, 16'($urandom), 40, 30);
        run_phase(10'd0, 16'hffff, 30, 20);
        run_phase(10'd3, 16'($urandom), 40, 25);
        run_phase(10'd1023, 16'd54613, 540, 3);
        run_phase(10'd64, 16'h0000, 80, 10);
        calm = 1'b1;
        run_phase(10'd2, 16'hffff, 40, 25);

        settle();
        repeat (64) @(posedge i_clk);
        if (meter_faults == 0 && words_in == words_out) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
src/alph_pkg.sv
src/audio_level_peak_hold_core.sv
dv/alph_level_checker.sv
dv/audio_level_peak_hold_core_test.sv
